/* hdl/rlrd_pkg.sv */
// Shared constants, types and helpers of the run-length row decoder.
package rlrd_pkg;

	localparam int MAX_WIDTH_BITS = 16;
	localparam int CMDQ_DEPTH     = 4;
	localparam int CMDQ_AW        = $clog2(CMDQ_DEPTH);
	localparam int OUTQ_DEPTH     = 2;
	localparam int OUTQ_AW        = $clog2(OUTQ_DEPTH);
	localparam int BYTES_W        = 18;

	localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

	// Configuration register indexes
	localparam logic REG_ROW_WIDTH    = 1'b0;
	localparam logic REG_SAMPLE_BYTES = 1'b1;

	// One unit of work handed from the front to the back: a run of
	// count copies of word (0 for an error, 1 for a literal).
	typedef struct packed {
		logic [15:0]        word;
		logic [6:0]         count;
		logic               done;
		logic               err;
		logic [BYTES_W-1:0] bytes;
	} cmd_t;

	typedef struct packed {
		logic [15:0]        pixel_first;
		logic [15:0]        pixel_second;
		logic [1:0]         pixel_count;
		logic               last_of_run;
		logic               row_done;
		logic               row_error;
		logic [BYTES_W-1:0] row_bytes;
	} res_t;

	// Word count to byte count, saturated.
	function automatic logic [BYTES_W-1:0] bytes_sat(input logic [BYTES_W:0] words,
							 input logic wide);
		logic [BYTES_W+1:0] b;
		b = wide ? {words, 1'b0} : {1'b0, words};
		return (b > {2'b00, BYTES_MAX}) ? BYTES_MAX : b[BYTES_W-1:0];
	endfunction

endpackage

/* hdl/rlrd_front.sv */
// Front end: register file, row state and classification of code words.
module rlrd_front import rlrd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        push,
	input  logic        func,
	input  logic [15:0] code_word,
	input  logic        q_full,
	output logic        cmd_push,
	output cmd_t        cmd
);

	typedef enum logic [1:0] {PH_HEADER, PH_LITERAL, PH_REPEAT} phase_t;

	phase_t                    phase_q, phase_n;
	logic [15:0]               row_width_q, width_n;
	logic                      wide_q;
	logic [6:0]                run_left_q, run_left_n;
	logic [MAX_WIDTH_BITS-1:0] pixels_left_q, pixels_left_n;
	logic [BYTES_W-1:0]        word_count_q, word_count_n;

	logic [MAX_WIDTH_BITS-1:0] eff_width, run_ext, rep_cnt, pl_after;
	logic [15:0]               word;
	logic [BYTES_W-1:0]        wc_inc;
	logic [6:0]                rl_dec;
	logic                      accept, restart;

	assign accept = push && !q_full;
	assign word   = wide_q ? code_word : {8'h00, code_word[7:0]};
	assign wc_inc = word_count_q + 1'b1;
	assign rl_dec = run_left_q - 1'b1;
	assign run_ext = {{(MAX_WIDTH_BITS-7){1'b0}}, run_left_q};
	assign rep_cnt = (run_ext < pixels_left_q) ? run_ext : pixels_left_q;

	assign width_n = (cfg_we && cfg_index == REG_ROW_WIDTH) ? cfg_data : row_width_q;
	assign eff_width = (width_n[MAX_WIDTH_BITS-1:0] == '0) ?
		MAX_WIDTH_BITS'(1) : width_n[MAX_WIDTH_BITS-1:0];

	always_comb begin
		phase_n       = phase_q;
		run_left_n    = run_left_q;
		pixels_left_n = pixels_left_q;
		word_count_n  = word_count_q;
		restart       = cfg_we;
		cmd_push      = 1'b0;
		cmd           = '0;
		pl_after      = pixels_left_q - rep_cnt;
		if (accept) begin
			if (func) begin
				cmd_push = 1'b1;
				cmd.err  = 1'b1;
				restart  = 1'b1;
			end else begin
				word_count_n = wc_inc;
				case (phase_q)
					PH_HEADER: begin
						if (word[6:0] == 7'd0) begin
							cmd_push = 1'b1;
							cmd.err  = 1'b1;
							restart  = 1'b1;
						end else begin
							run_left_n = word[6:0];
							phase_n    = word[7] ? PH_LITERAL : PH_REPEAT;
						end
					end
					PH_LITERAL: begin
						cmd_push      = 1'b1;
						cmd.word      = word;
						cmd.count     = 7'd1;
						pixels_left_n = pixels_left_q - 1'b1;
						run_left_n    = rl_dec;
						if (pixels_left_n == '0) begin
							// Length covers the unread rest of the literal run.
							cmd.done  = 1'b1;
							cmd.bytes = bytes_sat({1'b0, wc_inc} + {{(BYTES_W-6){1'b0}}, rl_dec},
									      wide_q);
							restart   = 1'b1;
						end else if (rl_dec == 7'd0) begin
							phase_n = PH_HEADER;
						end
					end
					PH_REPEAT: begin
						cmd_push      = 1'b1;
						cmd.word      = word;
						cmd.count     = rep_cnt[6:0];
						pixels_left_n = pl_after;
						run_left_n    = 7'd0;
						phase_n       = PH_HEADER;
						if (pl_after == '0) begin
							cmd.done  = 1'b1;
							cmd.bytes = bytes_sat({1'b0, wc_inc}, wide_q);
							restart   = 1'b1;
						end
					end
					default: begin
						phase_n = PH_HEADER;
					end
				endcase
			end
		end
		if (restart) begin
			phase_n       = PH_HEADER;
			run_left_n    = 7'd0;
			pixels_left_n = eff_width;
			word_count_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q   <= 16'd1;
			wide_q        <= 1'b0;
			phase_q       <= PH_HEADER;
			run_left_q    <= 7'd0;
			pixels_left_q <= MAX_WIDTH_BITS'(1);
			word_count_q  <= '0;
		end else begin
			row_width_q <= width_n;
			if (cfg_we && cfg_index == REG_SAMPLE_BYTES) begin
				wide_q <= cfg_data[1];
			end
			phase_q       <= phase_n;
			run_left_q    <= run_left_n;
			pixels_left_q <= pixels_left_n;
			word_count_q  <= word_count_n;
		end
	end

endmodule

/* hdl/rlrd_cmdq.sv */
// Short command queue between the front and back ends.
module rlrd_cmdq import rlrd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wr_cmd,
	input  logic rd,
	output cmd_t head,
	output logic full,
	output logic empty
);

	cmd_t               mem_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMDQ_AW:0]   cnt_q;

	assign full  = (cnt_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !wr)
		else $error("command queue written while full");

endmodule

/* hdl/rlrd_back.sv */
// Back end: expands commands into pixel pairs and buffers the results.
module rlrd_back import rlrd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t head,
	input  logic q_empty,
	output logic q_pop,
	input  logic pop,
	output logic empty,
	output res_t res
);

	res_t               oq_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0] owr_q, ord_q;
	logic [OUTQ_AW:0]   ocnt_q;
	logic [6:0]         sent_q, rem;
	logic [1:0]         n;
	logic               last, emit, oq_full, do_pop;
	res_t               nres;

	assign oq_full = (ocnt_q == (OUTQ_AW+1)'(OUTQ_DEPTH));
	assign empty   = (ocnt_q == '0);
	assign res     = oq_q[ord_q];
	assign do_pop  = pop && !empty;

	assign rem   = head.count - sent_q;
	assign n     = (rem >= 7'd2) ? 2'd2 : rem[1:0];
	assign last  = (rem <= 7'd2);
	assign emit  = !q_empty && !oq_full;
	assign q_pop = emit && last;

	always_comb begin
		nres.pixel_first  = head.word;
		nres.pixel_second = head.word;
		nres.pixel_count  = n;
		nres.last_of_run  = last;
		nres.row_done     = head.done && last;
		nres.row_error    = head.err;
		nres.row_bytes    = (head.done && last) ? head.bytes : '0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			oq_q[owr_q] <= nres;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q <= '0;
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (emit) begin
				sent_q <= last ? 7'd0 : sent_q + 7'd2;
				owr_q  <= owr_q + 1'b1;
			end
			if (do_pop) begin
				ord_q <= ord_q + 1'b1;
			end
			if (emit && !do_pop) begin
				ocnt_q <= ocnt_q + 1'b1;
			end else if (do_pop && !emit) begin
				ocnt_q <= ocnt_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/rle_row_decoder.sv */
// Top level of the run-length row decoder.
// Path: a transfer's command enters the command queue; the back end registers
//   its poppable results into the output buffer. Throughput: literal words one per cycle;
//   a repeat run of n pixels occupies the back end for ceil(n/2) results, and input
//   stalls only once the four-entry command queue between front and back fills.
// Reset: arst_n clears queues and row state; row_width resets to 1, 8-bit words.
module rle_row_decoder import rlrd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration writes
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	// input code words
	input  logic               push,
	output logic               full,
	input  logic               func,
	input  logic [15:0]        code_word,
	// decoded results
	output logic               empty,
	input  logic               pop,
	output logic [15:0]        pixel_first,
	output logic [15:0]        pixel_second,
	output logic [1:0]         pixel_count,
	output logic               last_of_run,
	output logic               row_done,
	output logic               row_error,
	output logic [BYTES_W-1:0] row_bytes
);

	cmd_t front_cmd, head_cmd;
	logic front_push, q_full, q_empty, q_pop;
	res_t res;

	// Front end: tracks phase and row position, turns each transfer into at
	// most one command (error, literal pixel or repeat run).
	rlrd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.func      (func),
		.code_word (code_word),
		.q_full    (q_full),
		.cmd_push  (front_push),
		.cmd       (front_cmd)
	);

	// Decouple classification from expansion so long repeat runs don't
	// stall the front immediately.
	rlrd_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (front_push),
		.wr_cmd (front_cmd),
		.rd     (q_pop),
		.head   (head_cmd),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Back end: emits up to two pixels a cycle into the output buffer while it has room.
	rlrd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head_cmd),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.res     (res)
	);

	// The front never holds a transfer of its own: full mirrors the queue.
	assign full         = q_full;
	assign pixel_first  = res.pixel_first;
	assign pixel_second = res.pixel_second;
	assign pixel_count  = res.pixel_count;
	assign last_of_run  = res.last_of_run;
	assign row_done     = res.row_done;
	assign row_error    = res.row_error;
	assign row_bytes    = res.row_bytes;

	// A row ends either way, never both.
	a_done_xor_err: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(row_done && row_error))
		else $error("result flags both row_done and row_error");

	// A row end always closes the item's results.
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (row_done || row_error)) |-> last_of_run)
		else $error("row end without last_of_run");

	// Error results carry no pixels and no length.
	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && row_error) |-> (pixel_count == 2'd0 && row_bytes == '0))
		else $error("error result carries pixels or length");

endmodule

/* test/rlrd_tb_pkg.sv */
`timescale 1ns / 100ps
// Input function codes shared by the row decoder's stimulus and checker.
package rlrd_tb_pkg;

	localparam logic FUNC_WORD = 1'b0;
	localparam logic FUNC_END  = 1'b1;

endpackage

/* test/rlrd_row_checker.sv */
`timescale 1ns / 100ps
// Row decoder checker: predicts decoded pixels from accepted transfers and compares results.
module rlrd_row_checker import rlrd_pkg::*, rlrd_tb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               push,
	input  logic               full,
	input  logic               func,
	input  logic [15:0]        code_word,
	input  logic               empty,
	input  logic               pop,
	input  logic [15:0]        pixel_first,
	input  logic [15:0]        pixel_second,
	input  logic [1:0]         pixel_count,
	input  logic               last_of_run,
	input  logic               row_done,
	input  logic               row_error,
	input  logic [BYTES_W-1:0] row_bytes,
	output int                 fail_count,
	output int                 pending
);

	typedef enum logic [1:0] {PH_HEADER, PH_LITERAL, PH_REPEAT} dec_phase_t;

	logic [15:0] row_width_q;
	logic [1:0]  sample_bytes_q;
	dec_phase_t  phase_q;
	int unsigned run_left_q;
	int unsigned pixels_left_q;
	int unsigned words_in_row;

	res_t decoded_due[$];

	function automatic bit wide_words();
		return sample_bytes_q >= 2'd2;
	endfunction

	function automatic logic [BYTES_W-1:0] bytes_for(input int unsigned words);
		logic [33:0] b;
		b = {2'b00, words};
		if (wide_words())
			b = b << 1;
		return (b > {16'd0, BYTES_MAX}) ? BYTES_MAX : b[BYTES_W-1:0];
	endfunction

	task automatic restart_row();
		int unsigned w;
		w = {16'd0, row_width_q} & ((32'd1 << MAX_WIDTH_BITS) - 1);
		phase_q       = PH_HEADER;
		run_left_q    = 0;
		pixels_left_q = (w == 0) ? 1 : w;
		words_in_row  = 0;
	endtask

	task automatic add_result(input logic [15:0] p1, input logic [15:0] p2,
				  input logic [1:0] cnt, input logic last, input logic done,
				  input logic err, input logic [BYTES_W-1:0] nbytes);
		res_t r;
		r.pixel_first  = p1;
		r.pixel_second = p2;
		r.pixel_count  = cnt;
		r.last_of_run  = last;
		r.row_done     = done;
		r.row_error    = err;
		r.row_bytes    = nbytes;
		decoded_due.push_back(r);
	endtask

	task automatic decode_item(input logic f, input logic [15:0] w);
		logic [15:0] v;
		int unsigned n, chunk;
		v = wide_words() ? w : {8'h00, w[7:0]};
		if (f == FUNC_END) begin
			add_result('0, '0, 2'd0, 1'b1, 1'b0, 1'b1, '0);
			restart_row();
		end else begin
			words_in_row++;
			case (phase_q)
				PH_HEADER: begin
					n = {25'd0, v[6:0]};
					if (n == 0) begin
						add_result('0, '0, 2'd0, 1'b1, 1'b0, 1'b1, '0);
						restart_row();
					end else begin
						run_left_q = n;
						phase_q    = v[7] ? PH_LITERAL : PH_REPEAT;
					end
				end
				PH_LITERAL: begin
					pixels_left_q--;
					run_left_q--;
					if (pixels_left_q == 0) begin
						// the whole run counts, unread words included
						add_result(v, v, 2'd1, 1'b1, 1'b1, 1'b0,
							   bytes_for(words_in_row + run_left_q));
						restart_row();
					end else begin
						add_result(v, v, 2'd1, 1'b1, 1'b0, 1'b0, '0);
						if (run_left_q == 0)
							phase_q = PH_HEADER;
					end
				end
				default: begin
					n = (run_left_q < pixels_left_q) ? run_left_q : pixels_left_q;
					pixels_left_q -= n;
					run_left_q = 0;
					phase_q    = PH_HEADER;
					while (n > 0) begin
						chunk = (n >= 2) ? 2 : 1;
						n -= chunk;
						if (n == 0 && pixels_left_q == 0)
							add_result(v, v, 2'(chunk), 1'b1, 1'b1, 1'b0,
								   bytes_for(words_in_row));
						else
							add_result(v, v, 2'(chunk), n == 0, 1'b0, 1'b0, '0);
					end
					if (pixels_left_q == 0)
						restart_row();
				end
			endcase
		end
	endtask

	task automatic cmp_field(input string name, input logic [31:0] want,
				 input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			decoded_due.delete();
			row_width_q    = 16'd1;
			sample_bytes_q = 2'd1;
			restart_row();
			pending <= 0;
		end else begin
			if (pop && !empty) begin
				if (decoded_due.size() == 0) begin
					$display("%0t: no result expected, got first %0h second %0h count %0d",
						 $time, pixel_first, pixel_second, pixel_count);
					fail_count++;
				end else begin
					want = decoded_due.pop_front();
					cmp_field("pixel_first", 32'(want.pixel_first), 32'(pixel_first));
					cmp_field("pixel_second", 32'(want.pixel_second),
						  32'(pixel_second));
					cmp_field("pixel_count", 32'(want.pixel_count), 32'(pixel_count));
					cmp_field("last_of_run", 32'(want.last_of_run), 32'(last_of_run));
					cmp_field("row_done", 32'(want.row_done), 32'(row_done));
					cmp_field("row_error", 32'(want.row_error), 32'(row_error));
					cmp_field("row_bytes", 32'(want.row_bytes), 32'(row_bytes));
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_ROW_WIDTH)
					row_width_q = cfg_data;
				else
					sample_bytes_q = cfg_data[1:0];
				restart_row();
			end
			if (push && !full)
				decode_item(func, code_word);
			pending <= decoded_due.size();
		end
	end

endmodule

/* test/tb_rle_row_decoder.sv */
`timescale 1ns / 100ps
// Testbench top of the run-length row decoder: stimulus, receiver, watchdog and verdict.
module tb_rle_row_decoder;
	import rlrd_pkg::*;
	import rlrd_tb_pkg::*;

	localparam int IDLE_PCT      = 16;
	localparam int HOLD_CYCLES   = 200;   // receiver hold-off, long enough to fill the block
	localparam int SETTLE_CYCLES = 8;     // a header word's latency plus margin
	localparam int QUIET_LIMIT   = 2000;  // cycles with no transfer before giving up

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_index;
	logic [15:0]        cfg_data;
	logic               push;
	logic               full;
	logic               func;
	logic [15:0]        code_word;
	logic               empty;
	logic               pop;
	logic [15:0]        pixel_first;
	logic [15:0]        pixel_second;
	logic [1:0]         pixel_count;
	logic               last_of_run;
	logic               row_done;
	logic               row_error;
	logic [BYTES_W-1:0] row_bytes;

	int fail_count;
	int pending;
	int quiet_cycles = 0;

	bit calm     = 1'b0;  // both sides stop idling while set
	bit hold_req = 1'b0;  // ask the receiver for one long hold-off

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rle_row_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.func         (func),
		.code_word    (code_word),
		.empty        (empty),
		.pop          (pop),
		.pixel_first  (pixel_first),
		.pixel_second (pixel_second),
		.pixel_count  (pixel_count),
		.last_of_run  (last_of_run),
		.row_done     (row_done),
		.row_error    (row_error),
		.row_bytes    (row_bytes)
	);

	rlrd_row_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.func         (func),
		.code_word    (code_word),
		.empty        (empty),
		.pop          (pop),
		.pixel_first  (pixel_first),
		.pixel_second (pixel_second),
		.pixel_count  (pixel_count),
		.last_of_run  (last_of_run),
		.row_done     (row_done),
		.row_error    (row_error),
		.row_bytes    (row_bytes),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// Watchdog: end the run once nothing has moved on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Receiver: pop at random, except during the calm stretch and the hold-off.
	initial begin
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				// hold pop low and let the block back up into full
				pop <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_req = 1'b0;
			end else if (calm) begin
				pop <= 1'b1;
			end else begin
				pop <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Offer one item and return right after the edge that takes the transfer.
	// Call only just after a rising edge. full only moves at an edge, so sample
	// it at the falling edge to know whether the next edge takes the item.
	task automatic send_item(input logic f, input logic [15:0] w);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push      <= 1'b1;
		func      <= f;
		code_word <= w;
		@(negedge clk);
		while (full)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Header word: literal flag in bit 7, count in bits 6:0, random upper byte.
	function automatic logic [15:0] hdr(input logic lit, input int unsigned cnt);
		logic [15:0] h;
		h      = 16'($urandom);
		h[7]   = lit;
		h[6:0] = cnt[6:0];
		return h;
	endfunction

	// Stop offering and wait until every expected result has been popped, then
	// let a header still in flight settle. The first edge lets the checker's
	// count catch up with the last transfer.
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Drain, then write both registers; unused sample_bytes bits get noise.
	task automatic configure(input logic [15:0] width, input logic [1:0] sbytes);
		logic [15:0] sb_word;
		sb_word      = 16'($urandom);
		sb_word[1:0] = sbytes;
		drain();
		write_reg(REG_ROW_WIDTH, width);
		write_reg(REG_SAMPLE_BYTES, sb_word);
	endtask

	// Run length: mostly short, now and then long, rarely near the maximum.
	function automatic int unsigned pick_count();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 88)
			return $urandom_range(8, 1);
		else if (r < 96)
			return $urandom_range(40, 9);
		return $urandom_range(127, 41);
	endfunction

	// Mostly well-formed runs with random content; the rest is end of data,
	// zero counts, and runs broken off by an end of data.
	task automatic random_burst(input int unsigned n_items);
		int unsigned sent, cnt, i, r;
		bit broken;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(99);
			if (r < 6) begin
				send_item(FUNC_END, 16'($urandom));
				sent++;
			end else if (r < 11) begin
				send_item(FUNC_WORD, hdr(1'($urandom_range(1)), 0));
				sent++;
			end else if (r < 55) begin
				cnt = pick_count();
				send_item(FUNC_WORD, hdr(1'b1, cnt));
				sent++;
				broken = 1'b0;
				i = 0;
				while (i < cnt && !broken) begin
					if ($urandom_range(99) < 3) begin
						send_item(FUNC_END, 16'($urandom));
						broken = 1'b1;
					end else begin
						send_item(FUNC_WORD, 16'($urandom));
					end
					sent++;
					i++;
				end
			end else begin
				cnt = pick_count();
				send_item(FUNC_WORD, hdr(1'b0, cnt));
				if ($urandom_range(99) < 4)
					send_item(FUNC_END, 16'($urandom));
				else
					send_item(FUNC_WORD, 16'($urandom));
				sent += 2;
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_ROW_WIDTH;
		cfg_data  = '0;
		push      = 1'b0;
		func      = FUNC_WORD;
		code_word = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: one-pixel rows of 8-bit words.
		send_item(FUNC_WORD, hdr(1'b1, 1));
		send_item(FUNC_WORD, 16'hFFFF);

		configure(16'd5, 2'd1);
		send_item(FUNC_WORD, hdr(1'b1, 2));
		send_item(FUNC_WORD, 16'h0000);
		send_item(FUNC_WORD, 16'hFFFF);
		// repeat run longer than the pixels still missing
		send_item(FUNC_WORD, hdr(1'b0, 127));
		send_item(FUNC_WORD, 16'hA5A5);
		// zero count with the literal flag set
		send_item(FUNC_WORD, hdr(1'b1, 0));
		// end of data inside a literal run
		send_item(FUNC_WORD, hdr(1'b1, 3));
		send_item(FUNC_WORD, 16'h5A5A);
		send_item(FUNC_END, 16'hFFFF);
		// end of data before a repeat value
		send_item(FUNC_WORD, hdr(1'b0, 2));
		send_item(FUNC_END, 16'h0000);
		// end of data while a header is due
		send_item(FUNC_END, 16'h1234);

		// 16-bit words: row filled inside a literal run, then the next
		// word is a new header (count zero here)
		configure(16'd2, 2'd2);
		send_item(FUNC_WORD, hdr(1'b1, 5));
		send_item(FUNC_WORD, 16'hFFFF);
		send_item(FUNC_WORD, 16'h0000);
		send_item(FUNC_WORD, 16'hFF00);

		// width zero acts as one pixel; sample_bytes 3 means 16-bit words
		configure(16'd0, 2'd3);
		send_item(FUNC_WORD, hdr(1'b0, 1));
		send_item(FUNC_WORD, 16'hFFFF);

		// sample_bytes 0 means 8-bit words: upper bytes are dropped
		configure(16'd4, 2'd0);
		send_item(FUNC_WORD, 16'h1283);
		send_item(FUNC_WORD, 16'hABCD);
		send_item(FUNC_WORD, 16'h5A01);
		send_item(FUNC_WORD, 16'h33FF);
		send_item(FUNC_WORD, 16'hFF01);
		send_item(FUNC_WORD, 16'h8080);

		// Random part over several settings.
		configure(16'($urandom_range(20, 3)), 2'd1);
		random_burst(35);

		// Hold the receiver off while the sender keeps offering.
		configure(16'($urandom_range(40, 1)), 2'd2);
		hold_req = 1'b1;
		random_burst(35);

		// Long stretch with no idling on either side.
		configure(16'($urandom_range(40, 1)), 2'd0);
		calm = 1'b1;
		random_burst(40);
		calm = 1'b0;

		configure(16'd1, 2'd3);
		random_burst(20);

		configure(16'($urandom_range(300, 41)), 2'd3);
		random_burst(20);

		drain();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
